### rtl/ltok_pkg.sv
// Shared types, codes and constants of the longest-match symbol tokenizer.
// No dependencies; ltok_front, ltok_back and the top level import this package.
package ltok_pkg;

  localparam int VOCAB_SIZE_DEF       = 256;
  localparam int MAX_SYMBOL_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH          = 4;

  // Table entry as stored: length on top of the packed symbol bytes.
  localparam int ENTRY_W = 4 + 64;

  // Commands of an input request.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_ID    = 2'd0;
  localparam logic [1:0] REG_END_ID      = 2'd1;
  localparam logic [1:0] REG_BLANK_TOKEN = 2'd2;
  localparam logic [1:0] REG_INTERLEAVE  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  byte_value;
    logic [7:0]  entry_index;
    logic [63:0] entry_bytes;
    logic [3:0]  entry_length;
  } item_t;

  typedef struct packed {
    logic [7:0]  token_id;
    logic        last;
    logic [15:0] dropped_count;
  } token_t;

  typedef struct packed {
    logic signed [8:0] start_id;
    logic signed [8:0] end_id;
    logic signed [8:0] blank_token;
    logic              interleave_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    K_LOAD,
    K_BYTE,
    K_END
  } kind_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    kind_t       kind;
    logic        slot_ok;
    logic [7:0]  byte_value;
    logic [7:0]  entry_index;
    logic [63:0] entry_bytes;
    logic [3:0]  entry_length;
  } qitem_t;

endpackage

### rtl/ltok_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltok_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/ltok_fifo.sv
// Small request queue between the front and back parts.
// No dependencies.
module ltok_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             not_empty
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;

  assign full      = (fill == (PW+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

### rtl/ltok_front.sv
// Front part: accepts requests, classifies them and queues them for the back part.
// Depends on ltok_pkg and ltok_fifo.
module ltok_front #(
  parameter int VOCAB_SIZE       = ltok_pkg::VOCAB_SIZE_DEF,
  parameter int MAX_SYMBOL_BYTES = ltok_pkg::MAX_SYMBOL_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  ltok_pkg::item_t item,
  output logic            item_stall,
  input  logic            hold,
  input  logic            pop,
  output logic            q_valid,
  output ltok_pkg::qitem_t q_head
);
  import ltok_pkg::*;

  localparam int QW = $bits(qitem_t);

  qitem_t         cls;
  logic           keep;
  logic           full;
  logic           push;
  logic [QW-1:0]  q_raw;

  always_comb begin
    cls             = '0;
    cls.byte_value  = item.byte_value;
    cls.entry_index = item.entry_index;
    cls.entry_bytes = item.entry_bytes;
    // overlong entries store as empty
    cls.entry_length = (int'(item.entry_length) > MAX_SYMBOL_BYTES) ? 4'd0 : item.entry_length;
    cls.slot_ok      = (int'(item.entry_index) < VOCAB_SIZE);
    keep             = 1'b1;
    case (item.command)
      CMD_LOAD: cls.kind = K_LOAD;
      CMD_BYTE: cls.kind = K_BYTE;
      CMD_END:  cls.kind = K_END;
      default: begin
        cls.kind = K_LOAD;
        keep     = 1'b0;  // drop unknown commands here
      end
    endcase
  end

  assign item_stall = hold || full;
  assign push       = item_valid && !item_stall && keep;
  assign q_head     = qitem_t'(q_raw);

  ltok_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (QW'(cls)),
    .pop       (pop),
    .rdata     (q_raw),
    .full      (full),
    .not_empty (q_valid)
  );
endmodule

### rtl/ltok_back.sv
// Back part: symbol table, lookahead buffer, table scan and result output.
// Depends on ltok_pkg and ltok_ram.
module ltok_back #(
  parameter int VOCAB_SIZE       = ltok_pkg::VOCAB_SIZE_DEF,
  parameter int MAX_SYMBOL_BYTES = ltok_pkg::MAX_SYMBOL_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ltok_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  ltok_pkg::qitem_t  q_head,
  output logic              pop,
  output logic              clearing,
  output logic              token_valid,
  input  logic              token_stall,
  output ltok_pkg::token_t  token
);
  import ltok_pkg::*;

  localparam int IW  = $clog2(VOCAB_SIZE);
  localparam int CW  = $clog2(MAX_SYMBOL_BYTES + 1);
  localparam int NW  = $clog2(VOCAB_SIZE + 1);
  localparam int MAX = MAX_SYMBOL_BYTES;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD_RD, S_LOAD_WR, S_BYTE, S_CHECK,
    S_SCAN, S_SCAN_END, S_DECIDE, S_BLANK, S_EMIT, S_FLUSH
  } state_t;

  state_t          state;
  state_t          ret_state;
  qitem_t          cur;
  logic [7:0]      emit_id;
  logic            pend_valid;
  logic [7:0]      pend_id;
  logic [7:0]      la [MAX];
  logic [CW-1:0]   la_count;
  logic [1:0]      skip_pending;
  logic            in_string;
  logic [15:0]     drop_counter;
  logic [NW-1:0]   len_count [1:MAX];
  logic [IW-1:0]   clr_k;
  logic [IW-1:0]   sc_k;
  logic            rd_pending;
  logic [IW-1:0]   rd_k;
  logic [3:0]      best_len;
  logic [IW-1:0]   best_id;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [3:0]      longest;
  logic [3:0]      wmax;
  logic [3:0]      threshold;
  logic [3:0]      ent_len;
  logic            match_ok;
  logic [2:0]      step;
  logic [3:0]      take;
  logic [3:0]      shift_amt;
  logic [7:0]      la_shift [MAX];
  logic            out_free;
  logic            out_load;
  logic            cur_end;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && q_valid;
  assign out_free = !token_valid || !token_stall;
  assign out_load = ((state == S_EMIT) || (state == S_FLUSH)) && pend_valid && out_free;
  assign cur_end  = (cur.kind == K_END);

  // Table write: clearing sweep or a load
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_k;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_LOAD_WR) begin
      ram_we    = 1'b1;
      ram_waddr = IW'(cur.entry_index);
      ram_wdata = {cur.entry_length, cur.entry_bytes};
    end
    ram_raddr = (state == S_LOAD_RD) ? IW'(cur.entry_index) : sc_k;
  end

  ltok_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VOCAB_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    longest = '0;
    for (int j = 1; j <= MAX; j++) begin
      if (len_count[j] != '0) longest = 4'(j);
    end
    wmax      = (int'(longest) < int'(la_count)) ? longest : 4'(la_count);
    threshold = (longest == '0) ? 4'd1 : longest;

    ent_len  = ram_rdata[ENTRY_W-1 -: 4];
    match_ok = (ent_len != '0) && (ent_len <= wmax);
    for (int j = 0; j < MAX; j++) begin
      if (j < int'(ent_len) && ram_rdata[8*j +: 8] != la[j]) match_ok = 1'b0;
    end

    // UTF-8 sequence length from the lead byte
    if ((la[0] & 8'hE0) == 8'hC0)      step = 3'd2;
    else if ((la[0] & 8'hF0) == 8'hE0) step = 3'd3;
    else if ((la[0] & 8'hF8) == 8'hF0) step = 3'd4;
    else                               step = 3'd1;
    take      = (int'(step) < int'(la_count)) ? 4'(step) : 4'(la_count);
    shift_amt = (best_len != '0) ? best_len : take;

    for (int i = 0; i < MAX; i++) begin
      la_shift[i] = la[i];
      for (int s = 0; s < MAX - i; s++) begin
        if (shift_amt == 4'(s)) la_shift[i] = la[i + s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ret_state    <= S_IDLE;
      clr_k        <= '0;
      pend_valid   <= 1'b0;
      token_valid  <= 1'b0;
      la_count     <= '0;
      skip_pending <= '0;
      in_string    <= 1'b0;
      drop_counter <= '0;
      rd_pending   <= 1'b0;
      for (int j = 1; j <= MAX; j++) len_count[j] <= '0;
    end else begin
      if (out_load) token_valid <= 1'b1;
      else if (token_valid && !token_stall) token_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          if (clr_k == IW'(VOCAB_SIZE - 1)) state <= S_IDLE;
          else clr_k <= clr_k + 1'b1;
        end

        S_IDLE: begin
          if (q_valid) begin
            cur <= q_head;
            case (q_head.kind)
              K_LOAD: if (q_head.slot_ok) state <= S_LOAD_RD;
              K_BYTE: begin
                if (!in_string) begin
                  in_string <= 1'b1;
                  if (!cfg.start_id[8]) begin
                    emit_id   <= cfg.start_id[7:0];
                    ret_state <= S_BYTE;
                    state     <= S_EMIT;
                  end else begin
                    state <= S_BYTE;
                  end
                end else begin
                  state <= S_BYTE;
                end
              end
              K_END: begin
                if (!in_string && !cfg.start_id[8]) begin
                  emit_id   <= cfg.start_id[7:0];
                  ret_state <= S_CHECK;
                  state     <= S_EMIT;
                end else begin
                  state <= S_CHECK;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_LOAD_RD: state <= S_LOAD_WR;

        S_LOAD_WR: begin
          // move one table entry from its old length to its new one
          for (int j = 1; j <= MAX; j++) begin
            len_count[j] <= len_count[j] - NW'(ent_len == 4'(j))
                                         + NW'(cur.entry_length == 4'(j));
          end
          state <= S_IDLE;
        end

        S_BYTE: begin
          if (skip_pending != '0) begin
            skip_pending <= skip_pending - 1'b1;
            state        <= S_FLUSH;
          end else begin
            if (int'(la_count) < MAX) begin
              for (int i = 0; i < MAX; i++) begin
                if (la_count == CW'(i)) la[i] <= cur.byte_value;
              end
              la_count <= la_count + 1'b1;
            end
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (cur_end) begin
            if (la_count != '0) begin
              sc_k     <= '0;
              best_len <= '0;
              state    <= S_SCAN;
            end else if (!cfg.end_id[8]) begin
              emit_id   <= cfg.end_id[7:0];
              ret_state <= S_FLUSH;
              state     <= S_EMIT;
            end else begin
              state <= S_FLUSH;
            end
          end else if (la_count != '0 && int'(la_count) >= int'(threshold)
                       && skip_pending == '0) begin
            sc_k     <= '0;
            best_len <= '0;
            state    <= S_SCAN;
          end else begin
            state <= S_FLUSH;
          end
        end

        S_SCAN, S_SCAN_END: begin
          // ascending scan keeps the lowest index among equal lengths
          if (rd_pending && match_ok && ent_len > best_len) begin
            best_len <= ent_len;
            best_id  <= rd_k;
          end
          if (state == S_SCAN) begin
            rd_pending <= 1'b1;
            rd_k       <= sc_k;
            if (sc_k == IW'(VOCAB_SIZE - 1)) state <= S_SCAN_END;
            else sc_k <= sc_k + 1'b1;
          end else begin
            rd_pending <= 1'b0;
            state      <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          for (int i = 0; i < MAX; i++) la[i] <= la_shift[i];
          la_count <= la_count - CW'(shift_amt);
          if (best_len != '0) begin
            emit_id   <= 8'(best_id);
            ret_state <= S_BLANK;
            state     <= S_EMIT;
          end else begin
            skip_pending <= 2'(step - 3'(take));
            if (drop_counter != 16'hFFFF) drop_counter <= drop_counter + 1'b1;
            state <= S_CHECK;
          end
        end

        S_BLANK: begin
          if (cfg.interleave_enable && !cfg.blank_token[8]) begin
            emit_id   <= cfg.blank_token[7:0];
            ret_state <= S_CHECK;
            state     <= S_EMIT;
          end else begin
            state <= S_CHECK;
          end
        end

        S_EMIT: begin
          // hold one result back so the final one of a string can carry last
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              token <= '{token_id: pend_id, last: 1'b0, dropped_count: 16'd0};
            end
            pend_valid <= 1'b1;
            pend_id    <= emit_id;
            state      <= ret_state;
          end
        end

        S_FLUSH: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              token <= '{token_id: pend_id, last: cur_end,
                        dropped_count: cur_end ? drop_counter : 16'd0};
            end
            pend_valid <= 1'b0;
            if (cur_end) begin
              in_string    <= 1'b0;
              la_count     <= '0;
              skip_pending <= '0;
              drop_counter <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("result held over between requests");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(la_count) <= MAX) else $error("lookahead overfilled");

  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    skip_pending != '0 |-> la_count == '0) else $error("skip with bytes buffered");

  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !pop) else $error("request taken during table clear");
endmodule

### rtl/longest_match_symbol_tokenizer.sv
// Top level of the greedy longest-match symbol tokenizer: configuration registers,
// front part and back part. Depends on ltok_pkg, ltok_front and ltok_back.
//
// Requests enter a four-deep queue and are worked one at a time by the back part.
// A table load reads the old entry, then writes the new one. A text byte is added
// to the lookahead, or swallowed as part of a dropped sequence.
// Every match decision scans the whole symbol table through its one RAM read
// port, one entry a cycle, and each result it hands out can wait while the
// result side stalls. After reset the table is swept to empty, during which no
// request is taken (configuration writes still land). Results leave through a
// registered output, one held back internally so the final one of a string can
// carry last and the drop count.
module longest_match_symbol_tokenizer #(
  parameter int VOCAB_SIZE       = ltok_pkg::VOCAB_SIZE_DEF,
  parameter int MAX_SYMBOL_BYTES = ltok_pkg::MAX_SYMBOL_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ltok_pkg::item_t  item,
  output logic             token_valid,
  input  logic             token_stall,
  output ltok_pkg::token_t token,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [8:0]       cfg_data
);
  import ltok_pkg::*;

  cfg_t   cfg;
  logic   q_valid;
  qitem_t q_head;
  logic   pop;
  logic   clearing;

  // Configuration registers; to be written only while the block is idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{start_id: 9'h1FF, end_id: 9'h1FF, blank_token: 9'h1FF,
               interleave_enable: 1'b0};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_ID:    cfg.start_id          <= cfg_data;
        REG_END_ID:      cfg.end_id            <= cfg_data;
        REG_BLANK_TOKEN: cfg.blank_token       <= cfg_data;
        REG_INTERLEAVE:  cfg.interleave_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold requests off while the table is being cleared
  ltok_front #(
    .VOCAB_SIZE       (VOCAB_SIZE),
    .MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .hold       (clearing),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_head     (q_head)
  );

  ltok_back #(
    .VOCAB_SIZE       (VOCAB_SIZE),
    .MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .clearing    (clearing),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );
endmodule
